FILE: rtl/core/clnws_pkg.sv
// Shared types and constants for the character LCD nibble write sequencer.
// Holds the microcode word layout, step addresses and fixed timing values.
// No dependencies.
package clnws_pkg;

    localparam int PC_W = 5;

    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_BYTE = 5'd0;
    localparam pc_t PC_INIT = 5'd2;

    typedef enum logic [1:0] {
        OP_COMMAND  = 2'd0,
        OP_DATA     = 2'd1,
        OP_POSITION = 2'd2,
        OP_INIT     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_ENABLE_PULSE = 2'd0,
        CFG_BYTE_GAP     = 2'd1,
        CFG_LONG_CMD     = 2'd2,
        CFG_POWER_UP     = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        NIB_HI,
        NIB_LO,
        NIB_LIT
    } nib_sel_t;

    typedef enum logic {
        BYTE_REQ,
        BYTE_LIT
    } byte_sel_t;

    typedef enum logic [2:0] {
        WAIT_ZERO,
        WAIT_POWER,
        WAIT_FIRST,
        WAIT_NIBBLE,
        WAIT_BYTE
    } wait_sel_t;

    typedef struct packed {
        nib_sel_t  nib_sel;
        byte_sel_t byte_sel;
        logic [7:0] lit;
        logic      strobe;
        wait_sel_t wait_sel;
        logic      last;
    } ucode_t;

    localparam logic [15:0] INIT_WAIT_FIRST_US  = 16'd5000;
    localparam logic [15:0] INIT_WAIT_NIBBLE_US = 16'd100;

    localparam logic [9:0]  BYTE_GAP_RESET  = 10'd45;
    localparam logic [15:0] LONG_CMD_RESET  = 16'd2000;
    localparam logic [15:0] POWER_UP_RESET  = 16'd15000;

    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;

endpackage

FILE: rtl/core/clnws_urom.sv
// Microcode store for the LCD nibble write sequencer.
// Maps a step address to its control word; depends on clnws_pkg.
// Steps 0..1 send one byte, steps 2..16 run the power-up initialization.
module clnws_urom
(
    input  clnws_pkg::pc_t   pc,
    output clnws_pkg::ucode_t cw
);
    import clnws_pkg::*;

    function automatic ucode_t uw(nib_sel_t ns, byte_sel_t bs, logic [7:0] lit,
                                  logic stb, wait_sel_t ws, logic lst);
        ucode_t w;
        w.nib_sel  = ns;
        w.byte_sel = bs;
        w.lit      = lit;
        w.strobe   = stb;
        w.wait_sel = ws;
        w.last     = lst;
        return w;
    endfunction

    always_comb
    begin
        unique case (pc)
            5'd0:    cw = uw(NIB_HI,  BYTE_REQ, 8'h00, 1'b1, WAIT_ZERO,   1'b0);
            5'd1:    cw = uw(NIB_LO,  BYTE_REQ, 8'h00, 1'b1, WAIT_BYTE,   1'b1);
            5'd2:    cw = uw(NIB_LIT, BYTE_REQ, 8'h00, 1'b0, WAIT_POWER,  1'b0);
            5'd3:    cw = uw(NIB_LIT, BYTE_REQ, 8'h03, 1'b1, WAIT_FIRST,  1'b0);
            5'd4:    cw = uw(NIB_LIT, BYTE_REQ, 8'h03, 1'b1, WAIT_NIBBLE, 1'b0);
            5'd5:    cw = uw(NIB_LIT, BYTE_REQ, 8'h03, 1'b1, WAIT_NIBBLE, 1'b0);
            5'd6:    cw = uw(NIB_LIT, BYTE_REQ, 8'h02, 1'b1, WAIT_NIBBLE, 1'b0);
            5'd7:    cw = uw(NIB_HI,  BYTE_LIT, CMD_FUNC_SET, 1'b1, WAIT_ZERO, 1'b0);
            5'd8:    cw = uw(NIB_LO,  BYTE_LIT, CMD_FUNC_SET, 1'b1, WAIT_BYTE, 1'b0);
            5'd9:    cw = uw(NIB_HI,  BYTE_LIT, CMD_DISP_OFF, 1'b1, WAIT_ZERO, 1'b0);
            5'd10:   cw = uw(NIB_LO,  BYTE_LIT, CMD_DISP_OFF, 1'b1, WAIT_BYTE, 1'b0);
            5'd11:   cw = uw(NIB_HI,  BYTE_LIT, CMD_CLEAR,    1'b1, WAIT_ZERO, 1'b0);
            5'd12:   cw = uw(NIB_LO,  BYTE_LIT, CMD_CLEAR,    1'b1, WAIT_BYTE, 1'b0);
            5'd13:   cw = uw(NIB_HI,  BYTE_LIT, CMD_ENTRY,    1'b1, WAIT_ZERO, 1'b0);
            5'd14:   cw = uw(NIB_LO,  BYTE_LIT, CMD_ENTRY,    1'b1, WAIT_BYTE, 1'b0);
            5'd15:   cw = uw(NIB_HI,  BYTE_LIT, CMD_DISP_ON,  1'b1, WAIT_ZERO, 1'b0);
            5'd16:   cw = uw(NIB_LO,  BYTE_LIT, CMD_DISP_ON,  1'b1, WAIT_BYTE, 1'b1);
            default: cw = uw(NIB_LIT, BYTE_REQ, 8'h00, 1'b0, WAIT_ZERO,   1'b1);
        endcase
    end

endmodule

FILE: rtl/core/char_lcd_nibble_write_sequencer_unit.sv
// Top level of the character LCD 4-bit write sequencer: request in, bus events out.
// Uses clnws_pkg and the microcode store clnws_urom.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------------
//   in      | in_valid / in_stall | operation, value, line, column
//   out     | out_valid/out_stall | nibble, register_select, strobe_res, wait_after_us, last
//   cfg     | cfg_we              | cfg_index, cfg_data
//
// One event leaves per cycle from the output register while out_stall is low; a step counter
// walks the microcode store. Byte requests run steps 0..1, initialization steps 2..16; the
// next request is taken in the cycle the final event is registered.
// Reset clears the step counter, busy flag and output valid, and loads the timing registers' defaults.
// A stalled output holds its event and the step counter waits with it.
module char_lcd_nibble_write_sequencer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  value,
    input  logic        line,
    input  logic [5:0]  column,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  nibble,
    output logic        register_select,
    output logic        strobe_res,
    output logic [15:0] wait_after_us,
    output logic        last,
    input  logic        cfg_we,
    input  clnws_pkg::cfg_idx_t cfg_index,
    input  logic [15:0] cfg_data
);
    import clnws_pkg::*;

    logic        busy_reg, busy_next;
    pc_t         pc_reg, pc_next;
    logic [7:0]  byte_reg, byte_next;
    logic        rs_reg, rs_next;
    logic [9:0]  gap_reg;
    logic [15:0] long_reg;
    logic [15:0] power_reg;

    logic        out_valid_reg, out_valid_next;
    logic [3:0]  nibble_reg, nibble_next;
    logic        rs_out_reg, rs_out_next;
    logic        strobe_reg, strobe_next;
    logic [15:0] wait_reg, wait_next;
    logic        last_reg, last_next;

    ucode_t      cw;
    logic        emit;
    logic        accept;
    logic [7:0]  cur_byte;
    logic        long_cmd;
    logic [16:0] byte_wait_sum;
    logic [15:0] byte_wait;

    clnws_urom u_urom
    (
        .pc (pc_reg),
        .cw (cw)
    );

    assign emit     = busy_reg && (!out_valid_reg || !out_stall);
    assign in_stall = busy_reg && !(emit && cw.last);
    assign accept   = in_valid && !in_stall;

    assign cur_byte      = (cw.byte_sel == BYTE_LIT) ? cw.lit : byte_reg;
    assign long_cmd      = !rs_reg && (cur_byte != 8'h00) && (cur_byte <= 8'h03);
    assign byte_wait_sum = {7'd0, gap_reg} + (long_cmd ? {1'b0, long_reg} : 17'd0);
    assign byte_wait     = byte_wait_sum[16] ? 16'hFFFF : byte_wait_sum[15:0];

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        byte_next = byte_reg;
        rs_next   = rs_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = (op_t'(operation) == OP_INIT) ? PC_INIT : PC_BYTE;
            rs_next   = (op_t'(operation) == OP_DATA);
            unique case (op_t'(operation))
                OP_POSITION: byte_next = {1'b1, line, column};
                default:     byte_next = value;
            endcase
        end
        else if (emit)
        begin
            if (cw.last)
                busy_next = 1'b0;
            else
                pc_next = pc_reg + pc_t'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        nibble_next    = nibble_reg;
        rs_out_next    = rs_out_reg;
        strobe_next    = strobe_reg;
        wait_next      = wait_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            rs_out_next    = rs_reg;
            strobe_next    = cw.strobe;
            last_next      = cw.last;
            unique case (cw.nib_sel)
                NIB_HI:  nibble_next = cur_byte[7:4];
                NIB_LO:  nibble_next = cur_byte[3:0];
                default: nibble_next = cw.lit[3:0];
            endcase
            unique case (cw.wait_sel)
                WAIT_POWER:  wait_next = power_reg;
                WAIT_FIRST:  wait_next = INIT_WAIT_FIRST_US;
                WAIT_NIBBLE: wait_next = INIT_WAIT_NIBBLE_US;
                WAIT_BYTE:   wait_next = byte_wait;
                default:     wait_next = 16'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= PC_BYTE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg   <= BYTE_GAP_RESET;
            long_reg  <= LONG_CMD_RESET;
            power_reg <= POWER_UP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BYTE_GAP: gap_reg   <= cfg_data[9:0];
                CFG_LONG_CMD: long_reg  <= cfg_data;
                CFG_POWER_UP: power_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        rs_reg     <= rs_next;
        nibble_reg <= nibble_next;
        rs_out_reg <= rs_out_next;
        strobe_reg <= strobe_next;
        wait_reg   <= wait_next;
        last_reg   <= last_next;
    end

    assign out_valid       = out_valid_reg;
    assign nibble          = nibble_reg;
    assign register_select = rs_out_reg;
    assign strobe_res      = strobe_reg;
    assign wait_after_us   = wait_reg;
    assign last            = last_reg;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("request accepted but sequencer not busy");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg <= 5'd16))
        else $error("step counter left the program");

    a_wait_event: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !strobe_reg) |-> (nibble_reg == 4'd0 && !rs_out_reg && !last_reg))
        else $error("unstrobed event other than power-up wait");
`endif

endmodule

FILE: test/lcd_event_checker.sv
// Checker for the character LCD 4-bit write sequencer: watches the request, event
// and register ports, predicts the bus events of each request and compares them.
// Depends on clnws_pkg for the operation and register index types.
module lcd_event_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [1:0]          operation,
    input  logic [7:0]          value,
    input  logic                line,
    input  logic [5:0]          column,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [3:0]          nibble,
    input  logic                register_select,
    input  logic                strobe_res,
    input  logic [15:0]         wait_after_us,
    input  logic                last,
    input  logic                cfg_we,
    input  clnws_pkg::cfg_idx_t cfg_index,
    input  logic [15:0]         cfg_data,
    output int                  mismatch_count,
    output int                  outstanding
);
    import clnws_pkg::*;

    localparam logic [7:0]  LCD_FUNCTION_SET = 8'h28;
    localparam logic [7:0]  LCD_DISPLAY_OFF  = 8'h08;
    localparam logic [7:0]  LCD_CLEAR        = 8'h01;
    localparam logic [7:0]  LCD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0]  LCD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0]  LCD_SET_DDRAM    = 8'h80;
    localparam logic [7:0]  LCD_LINE_OFFSET  = 8'h40;
    localparam logic [16:0] WAKE_FIRST_US    = 17'd5000;
    localparam logic [16:0] WAKE_NIBBLE_US   = 17'd100;

    typedef struct packed {
        logic [3:0]  nib;
        logic        rs;
        logic        strobe;
        logic [15:0] wait_us;
        logic        fin;
    } bus_event_t;

    bus_event_t  expected_events[$];
    logic [7:0]  pulse_us;
    logic [9:0]  gap_us;
    logic [15:0] long_us;
    logic [15:0] power_us;

    task automatic report_mismatch(input string what);
        $display("checker: %0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void push_bus_event(input logic [3:0] nib, input logic rs,
                                           input logic strobe, input logic [16:0] wait_sum,
                                           input logic fin);
        bus_event_t ev;
        ev.nib     = nib;
        ev.rs      = rs;
        ev.strobe  = strobe;
        ev.wait_us = wait_sum[16] ? 16'hFFFF : wait_sum[15:0];
        ev.fin     = fin;
        expected_events.push_back(ev);
    endfunction

    function automatic void push_byte_events(input logic [7:0] b, input logic rs,
                                             input logic fin);
        logic [16:0] wait_sum;
        wait_sum = {7'd0, gap_us};
        // clear and home commands need the long settle time
        if (!rs && b >= 8'd1 && b <= 8'd3)
            wait_sum = wait_sum + {1'b0, long_us};
        push_bus_event(b[7:4], rs, 1'b1, 17'd0, 1'b0);
        push_bus_event(b[3:0], rs, 1'b1, wait_sum, fin);
    endfunction

    function automatic void predict_bus_events(input op_t op, input logic [7:0] val,
                                               input logic ln, input logic [5:0] col);
        case (op)
            OP_COMMAND:  push_byte_events(val, 1'b0, 1'b1);
            OP_DATA:     push_byte_events(val, 1'b1, 1'b1);
            OP_POSITION: push_byte_events(LCD_SET_DDRAM + {2'b00, col}
                                          + (ln ? LCD_LINE_OFFSET : 8'h00), 1'b0, 1'b1);
            default:
            begin
                push_bus_event(4'h0, 1'b0, 1'b0, {1'b0, power_us}, 1'b0);
                push_bus_event(4'h3, 1'b0, 1'b1, WAKE_FIRST_US, 1'b0);
                push_bus_event(4'h3, 1'b0, 1'b1, WAKE_NIBBLE_US, 1'b0);
                push_bus_event(4'h3, 1'b0, 1'b1, WAKE_NIBBLE_US, 1'b0);
                push_bus_event(4'h2, 1'b0, 1'b1, WAKE_NIBBLE_US, 1'b0);
                push_byte_events(LCD_FUNCTION_SET, 1'b0, 1'b0);
                push_byte_events(LCD_DISPLAY_OFF, 1'b0, 1'b0);
                push_byte_events(LCD_CLEAR, 1'b0, 1'b0);
                push_byte_events(LCD_ENTRY_MODE, 1'b0, 1'b0);
                push_byte_events(LCD_DISPLAY_ON, 1'b0, 1'b1);
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bus_event_t got;
        bus_event_t want;
        if (!rst_n)
        begin
            expected_events.delete();
            pulse_us       = 8'd1;
            gap_us         = 10'd45;
            long_us        = 16'd2000;
            power_us       = 16'd15000;
            mismatch_count = 0;
            outstanding    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE_PULSE: pulse_us = cfg_data[7:0];
                    CFG_BYTE_GAP:     gap_us   = cfg_data[9:0];
                    CFG_LONG_CMD:     long_us  = cfg_data;
                    CFG_POWER_UP:     power_us = cfg_data;
                    default:          ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_bus_events(op_t'(operation), value, line, column);
            if (out_valid && !out_stall)
            begin
                got = {nibble, register_select, strobe_res, wait_after_us, last};
                if (expected_events.size() == 0)
                    report_mismatch($sformatf("unexpected event nib %h rs %b strobe %b wait %0d last %b",
                                              got.nib, got.rs, got.strobe, got.wait_us, got.fin));
                else
                begin
                    want = expected_events.pop_front();
                    if (got.nib != want.nib || got.rs != want.rs || got.strobe != want.strobe
                        || got.wait_us != want.wait_us || got.fin != want.fin)
                        report_mismatch($sformatf(
                            "event nib %h/%h rs %b/%b strobe %b/%b wait %0d/%0d last %b/%b (got/exp)",
                            got.nib, want.nib, got.rs, want.rs, got.strobe, want.strobe,
                            got.wait_us, want.wait_us, got.fin, want.fin));
                end
            end
            outstanding = expected_events.size();
        end
    end

endmodule

FILE: test/tb.sv
// Testbench top for the character LCD 4-bit write sequencer: drives requests,
// register writes and output stalls, and gives the verdict.
// Depends on clnws_pkg, the sequencer RTL and lcd_event_checker.
module tb;
    import clnws_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  operation;
    logic [7:0]  value;
    logic        line;
    logic [5:0]  column;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  nibble;
    logic        register_select;
    logic        strobe_res;
    logic [15:0] wait_after_us;
    logic        last;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [15:0] cfg_data;
    int          mismatch_count;
    int          outstanding;
    int          send_idle_pct;
    int          recv_idle_pct;

    char_lcd_nibble_write_sequencer_unit u_top (.*);

    lcd_event_checker u_checker (.*);

    always #5 clk = ~clk;

    always @(negedge clk)
        out_stall = ($urandom_range(0, 99) < recv_idle_pct);

    task automatic send_request(input op_t op, input logic [7:0] val, input logic ln,
                                input logic [5:0] col);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        operation = op;
        value     = val;
        line      = ln;
        column    = col;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_requests(input int count);
        op_t        op;
        logic [7:0] val;
        repeat (count)
        begin
            op  = ($urandom_range(0, 15) == 0) ? OP_INIT : op_t'($urandom_range(0, 2));
            val = 8'($urandom_range(0, 255));
            // favor the bytes around the long-wait commands
            if ($urandom_range(0, 3) == 0)
                val = 8'($urandom_range(0, 4));
            send_request(op, val, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
        end
    endtask

    task automatic wait_for_drain();
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [15:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = OP_COMMAND;
        value         = 8'h00;
        line          = 1'b0;
        column        = 6'd0;
        out_stall     = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_ENABLE_PULSE;
        cfg_data      = 16'd0;
        send_idle_pct = 26;
        recv_idle_pct = 58;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        send_request(OP_INIT, 8'h00, 1'b0, 6'd0);
        send_request(OP_COMMAND, 8'h00, 1'b0, 6'd0);
        send_request(OP_COMMAND, 8'h01, 1'b1, 6'd63);
        send_request(OP_COMMAND, 8'h02, 1'b0, 6'd0);
        send_request(OP_COMMAND, 8'h03, 1'b1, 6'd63);
        send_request(OP_COMMAND, 8'h04, 1'b0, 6'd0);
        send_request(OP_COMMAND, 8'hFF, 1'b1, 6'd63);
        send_request(OP_DATA, 8'h00, 1'b0, 6'd0);
        send_request(OP_DATA, 8'h01, 1'b0, 6'd0);
        send_request(OP_DATA, 8'h03, 1'b0, 6'd0);
        send_request(OP_DATA, 8'hFF, 1'b1, 6'd63);
        send_request(OP_DATA, 8'hA5, 1'b0, 6'd21);
        send_request(OP_POSITION, 8'h00, 1'b0, 6'd0);
        send_request(OP_POSITION, 8'hFF, 1'b1, 6'd63);
        send_request(OP_POSITION, 8'h00, 1'b0, 6'd63);
        send_request(OP_POSITION, 8'hFF, 1'b1, 6'd0);
        send_request(OP_INIT, 8'hFF, 1'b1, 6'd63);
        wait_for_drain();

        write_register(CFG_ENABLE_PULSE, 16'd255);
        write_register(CFG_BYTE_GAP, 16'd1023);
        write_register(CFG_LONG_CMD, 16'hFFFF);
        write_register(CFG_POWER_UP, 16'hFFFF);
        send_request(OP_COMMAND, 8'h01, 1'b0, 6'd0);
        send_request(OP_COMMAND, 8'h02, 1'b0, 6'd0);
        send_request(OP_COMMAND, 8'h03, 1'b0, 6'd0);
        send_request(OP_COMMAND, 8'h04, 1'b0, 6'd0);
        send_request(OP_INIT, 8'h00, 1'b0, 6'd0);
        send_random_requests(95);
        wait_for_drain();

        send_idle_pct = 58;
        recv_idle_pct = 26;
        write_register(CFG_ENABLE_PULSE, 16'h0100);
        write_register(CFG_BYTE_GAP, 16'hFC00);
        write_register(CFG_LONG_CMD, 16'd0);
        write_register(CFG_POWER_UP, 16'd0);
        send_request(OP_INIT, 8'h00, 1'b0, 6'd0);
        send_random_requests(99);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(CFG_ENABLE_PULSE, 16'($urandom_range(0, 65535)));
        write_register(CFG_BYTE_GAP, 16'($urandom_range(0, 65535)));
        write_register(CFG_LONG_CMD, 16'($urandom_range(0, 65535)));
        write_register(CFG_POWER_UP, 16'($urandom_range(0, 65535)));
        send_random_requests(100);
        wait_for_drain();
        repeat (20) @(negedge clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule
